FILE: hdl/eva_pkg.sv
//------------------------------------------------------------------------------
// eva_pkg
// Shared types, character codes and helpers of the enum value assigner.
//------------------------------------------------------------------------------
`default_nettype none

package eva_pkg;

    // Payload widths fixed by the item format.
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 31;

    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [VALUE_W-1:0] t_value;

    // Largest value an enumerator can take.
    localparam t_value VALUE_TOP = {VALUE_W{1'b1}};

    // Characters with a meaning in the statement text.
    localparam t_char CH_LBRACE = 8'h7B;
    localparam t_char CH_RBRACE = 8'h7D;
    localparam t_char CH_EQUALS = 8'h3D;
    localparam t_char CH_COMMA  = 8'h2C;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_UNDER  = 8'h5F;
    localparam t_char CH_ZERO   = 8'h30;
    localparam t_char CH_NINE   = 8'h39;
    localparam t_char CH_LC_A   = 8'h61;
    localparam t_char CH_LC_Z   = 8'h7A;
    localparam t_char CH_UC_A   = 8'h41;
    localparam t_char CH_UC_Z   = 8'h5A;

    // Emission job handed from the parser to the name buffer.
    typedef struct packed {
        logic   start;
        logic   trunc;
        t_value value;
    } t_job;

    // Write of one name character into the name buffer.
    typedef struct packed {
        logic  en;
        t_char data;
    } t_wr;

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_name_char(input t_char c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) ||
               ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
               is_digit(c) || (c == CH_UNDER);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/eva_in_if.sv
//------------------------------------------------------------------------------
// eva_in_if
// Input channel: one statement byte per item with a start-of-statement mark.
//------------------------------------------------------------------------------
`default_nettype none

interface eva_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       statement_start;

    modport source (output valid, output text_byte, output statement_start, input ready);
    modport sink   (input valid, input text_byte, input statement_start, output ready);
endinterface

`default_nettype wire

FILE: hdl/eva_out_if.sv
//------------------------------------------------------------------------------
// eva_out_if
// Output channel: one enumerator name character per item with its value.
//------------------------------------------------------------------------------
`default_nettype none

interface eva_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  name_char;
    logic [4:0]  char_pos;
    logic [30:0] item_value;
    logic        last;
    logic        truncated;

    modport source (output valid, output name_char, output char_pos, output item_value,
                    output last, output truncated, input ready);
    modport sink   (input valid, input name_char, input char_pos, input item_value,
                    input last, input truncated, output ready);
endinterface

`default_nettype wire

FILE: hdl/eva_parser.sv
//------------------------------------------------------------------------------
// eva_parser
// Byte parser: tracks the brace, name and value state and starts emission jobs.
//------------------------------------------------------------------------------
`default_nettype none

module eva_parser #(
    parameter int NAME_MAX = 19
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    eva_in_if.sink                           i_item,
    input  wire                              i_idle,
    output logic [$clog2(NAME_MAX+1)-1:0]    o_len,
    output eva_pkg::t_wr                     o_wr,
    output eva_pkg::t_job                    o_job
);
    import eva_pkg::*;

    localparam int LW = $clog2(NAME_MAX + 1);

    // Parse modes.
    localparam logic [1:0] MODE_BETWEEN = 2'd0;
    localparam logic [1:0] MODE_NAME    = 2'd1;
    localparam logic [1:0] MODE_VALUE   = 2'd2;

    logic          r_seeking, n_seeking;
    logic [1:0]    r_mode, n_mode;
    logic [LW-1:0] r_len, n_len;
    t_value        r_next_value, n_next_value;
    t_value        r_acc, n_acc;
    logic          r_digits_open, n_digits_open;
    logic          r_overflow, n_overflow;

    // State as seen by the current byte, after an optional statement restart.
    logic          s_seeking;
    logic [1:0]    s_mode;
    logic [LW-1:0] s_len;
    t_value        s_next_value;
    t_value        s_acc;
    logic          s_digits_open;
    logic          s_overflow;

    logic                 accept;
    t_char                c;
    logic [VALUE_W+3:0]   acc_x10;
    t_value               acc_sat;
    t_value               val;

    assign i_item.ready = i_idle;
    assign accept       = i_item.valid && i_idle;
    assign c            = i_item.text_byte;

    always_comb begin
        if (i_item.statement_start) begin
            s_seeking     = 1'b1;
            s_mode        = MODE_NAME;
            s_len         = '0;
            s_next_value  = '0;
            s_acc         = '0;
            s_digits_open = 1'b1;
            s_overflow    = 1'b0;
        end else begin
            s_seeking     = r_seeking;
            s_mode        = r_mode;
            s_len         = r_len;
            s_next_value  = r_next_value;
            s_acc         = r_acc;
            s_digits_open = r_digits_open;
            s_overflow    = r_overflow;
        end
    end

    // Decimal accumulation as a shift-add, saturating at the top value.
    assign acc_x10 = {1'b0, s_acc, 3'b000} + {3'b000, s_acc, 1'b0} + (VALUE_W+4)'(c[3:0]);
    assign acc_sat = (acc_x10 > (VALUE_W+4)'(VALUE_TOP)) ? VALUE_TOP : acc_x10[VALUE_W-1:0];
    assign val     = (s_mode == MODE_VALUE) ? s_acc : s_next_value;

    // Next state for the accepted byte.
    always_comb begin
        n_seeking     = r_seeking;
        n_mode        = r_mode;
        n_len         = r_len;
        n_next_value  = r_next_value;
        n_acc         = r_acc;
        n_digits_open = r_digits_open;
        n_overflow    = r_overflow;
        o_wr.en       = 1'b0;
        o_wr.data     = c;
        o_job.start   = 1'b0;
        o_job.trunc   = s_overflow;
        o_job.value   = val;
        o_len         = s_len;
        if (accept) begin
            n_seeking     = s_seeking;
            n_mode        = s_mode;
            n_len         = s_len;
            n_next_value  = s_next_value;
            n_acc         = s_acc;
            n_digits_open = s_digits_open;
            n_overflow    = s_overflow;
            priority if (s_seeking) begin
                if (c == CH_LBRACE) begin
                    n_seeking = 1'b0;
                end
            end else if (c == CH_SPACE) begin
                n_seeking = s_seeking;
            end else if (is_name_char(c)) begin
                if (s_mode == MODE_VALUE) begin
                    if (s_digits_open && is_digit(c)) begin
                        n_acc = acc_sat;
                    end else begin
                        n_digits_open = 1'b0;
                    end
                end else begin
                    n_mode = MODE_NAME;
                    if (s_len < LW'(NAME_MAX)) begin
                        o_wr.en = 1'b1;
                        n_len   = s_len + LW'(1);
                    end else begin
                        n_overflow = 1'b1;
                    end
                end
            end else if (c == CH_EQUALS) begin
                n_mode        = MODE_VALUE;
                n_acc         = '0;
                n_digits_open = 1'b1;
            end else if ((c == CH_COMMA) || (c == CH_RBRACE)) begin
                // A nonempty name is handed to the buffer for read-out.
                if (((s_mode == MODE_NAME) || (s_mode == MODE_VALUE)) && (s_len != '0)) begin
                    o_job.start  = 1'b1;
                    n_next_value = (val == VALUE_TOP) ? VALUE_TOP : val + VALUE_W'(1);
                end
                n_mode        = MODE_BETWEEN;
                n_len         = '0;
                n_overflow    = 1'b0;
                n_acc         = '0;
                n_digits_open = 1'b1;
            end else begin
                n_seeking = s_seeking;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeking     <= 1'b1;
            r_mode        <= MODE_NAME;
            r_len         <= '0;
            r_next_value  <= '0;
            r_acc         <= '0;
            r_digits_open <= 1'b1;
            r_overflow    <= 1'b0;
        end else begin
            r_seeking     <= n_seeking;
            r_mode        <= n_mode;
            r_len         <= n_len;
            r_next_value  <= n_next_value;
            r_acc         <= n_acc;
            r_digits_open <= n_digits_open;
            r_overflow    <= n_overflow;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/eva_name_buf.sv
//------------------------------------------------------------------------------
// eva_name_buf
// Name store with a registered read port and the character read-out pipeline.
//------------------------------------------------------------------------------
`default_nettype none

module eva_name_buf #(
    parameter int NAME_MAX = 19
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire [$clog2(NAME_MAX+1)-1:0]     i_len,
    input  eva_pkg::t_wr                     i_wr,
    input  eva_pkg::t_job                    i_job,
    output logic                             o_idle,
    eva_out_if.source                        o_item
);
    import eva_pkg::*;

    localparam int LW = $clog2(NAME_MAX + 1);
    localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

    t_char mem [NAME_MAX];

    // Job registers.
    logic          r_busy;
    logic [LW-1:0] r_k;
    logic [LW-1:0] r_len;
    t_value        r_value;
    logic          r_trunc;

    // Read stage.
    logic          r_rd_valid;
    t_char         r_rd_data;
    logic [LW-1:0] r_rd_pos;
    logic          r_rd_last;
    t_value        r_rd_value;
    logic          r_rd_trunc;

    // Output register.
    logic          r_out_valid;
    t_char         r_out_char;
    logic [POS_W-1:0] r_out_pos;
    t_value        r_out_value;
    logic          r_out_last;
    logic          r_out_trunc;

    logic          take;
    logic          move;
    logic          issue;
    logic [LW-1:0] k_inc;
    logic          k_last;

    assign take   = r_out_valid && o_item.ready;
    assign move   = r_rd_valid && (!r_out_valid || take);
    assign issue  = r_busy && (!r_rd_valid || move);
    assign k_inc  = r_k + LW'(1);
    assign k_last = (k_inc == r_len);
    assign o_idle = !r_busy;

    // Characters are written while the input side is open; reads happen only
    // while a job holds the input off, so the two never meet on one entry.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_len[AW-1:0]] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= mem[r_k[AW-1:0]];
        end
    end

    // Job counter walks the stored name one entry per issued read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_job.start) begin
            r_busy <= 1'b1;
        end else if (issue && k_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.start) begin
            r_k     <= '0;
            r_len   <= i_len;
            r_value <= i_job.value;
            r_trunc <= i_job.trunc;
        end else if (issue) begin
            r_k <= k_inc;
        end
    end

    // Read stage side information travels with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (issue) begin
            r_rd_valid <= 1'b1;
        end else if (move) begin
            r_rd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_pos   <= r_k;
            r_rd_last  <= k_last;
            r_rd_value <= r_value;
            r_rd_trunc <= r_trunc;
        end
    end

    // Output register holds an item until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_char  <= r_rd_data;
            r_out_pos   <= POS_W'(r_rd_pos);
            r_out_value <= r_rd_value;
            r_out_last  <= r_rd_last;
            r_out_trunc <= r_rd_trunc;
        end
    end

    assign o_item.valid      = r_out_valid;
    assign o_item.name_char  = r_out_char;
    assign o_item.char_pos   = r_out_pos;
    assign o_item.item_value = r_out_value;
    assign o_item.last       = r_out_last;
    assign o_item.truncated  = r_out_trunc;

endmodule

`default_nettype wire

FILE: hdl/enum_value_assigner.sv
//------------------------------------------------------------------------------
// enum_value_assigner
// Parses C enum statement text and emits each enumerator name with its value.
//------------------------------------------------------------------------------
// Usage:
// i_item carries one statement byte per item; statement_start on a byte
// restarts parsing with that byte. o_item carries one name character per
// item with its position, the enumerator value, a last mark and a flag for
// names longer than NAME_MAX characters (the excess is dropped).
// Most bytes are taken at one per cycle. A ',' or '}' that closes a
// nonempty name holds i_item.ready low while the name store is read, one
// entry per cycle through its registered port. After the delimiter is taken
// the first character passes the job registers, the read stage and the
// output register to o_item; the rest follow one per cycle while the receiver keeps up.
// A stalled receiver holds the output register and the read stage; the
// read-out then waits, and with it the input side.
// Reset clears the parse state and empties the output; the name store is
// not cleared, since only entries written for the current name are read.
//------------------------------------------------------------------------------
`default_nettype none

module enum_value_assigner #(
    parameter int NAME_MAX = 19
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    eva_in_if.sink     i_item,
    eva_out_if.source  o_item
);
    import eva_pkg::*;

    localparam int LW = $clog2(NAME_MAX + 1);

    logic          idle;
    logic [LW-1:0] len;
    t_wr           wr;
    t_job          job;

    eva_parser #(.NAME_MAX(NAME_MAX)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_idle  (idle),
        .o_len   (len),
        .o_wr    (wr),
        .o_job   (job)
    );

    eva_name_buf #(.NAME_MAX(NAME_MAX)) u_name_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len   (len),
        .i_wr    (wr),
        .i_job   (job),
        .o_idle  (idle),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

FILE: hdl/eva_checker.sv
//------------------------------------------------------------------------------
// eva_checker
// Port-level checks of the enum value assigner, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module eva_checker #(
    parameter int NAME_MAX = 19
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [4:0]  i_char_pos,
    input wire [7:0]  i_name_char,
    input wire        i_last,
    input wire        i_truncated
);

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output item valid right after reset");

    // A stalled item keeps its character.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_name_char)
                                        && $stable(i_char_pos))
        else $error("stalled output item changed");

    // A name with dropped characters fills the whole store.
    a_trunc_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last && i_truncated |-> i_char_pos == 5'(NAME_MAX - 1))
        else $error("truncated name ended before the store was full");

    // The final store position always closes the name.
    a_pos_top_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_char_pos == 5'(NAME_MAX - 1)) && (NAME_MAX <= 32) |-> i_last)
        else $error("character at the last store position not marked last");

endmodule

bind enum_value_assigner eva_checker #(.NAME_MAX(NAME_MAX)) u_eva_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_char_pos  (o_item.char_pos),
    .i_name_char (o_item.name_char),
    .i_last      (o_item.last),
    .i_truncated (o_item.truncated)
);

`default_nettype wire
